// ----- hw/rtl/uhp_pkg.sv -----
`timescale 1ns / 1ps

package uhp_pkg;

	localparam int HOST_MAX_DEF        = 256;
	localparam int PORT_DIGITS_MAX_DEF = 6;

	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 8;
	localparam int LEN_W   = 9;
	localparam int PORT_W  = 16;
	localparam int DIG_W   = 3;
	localparam int ACC_W   = 20;

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2d;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3a;
	localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5a;
	localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7a;

	localparam logic KIND_HOST   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_ERR  = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [INDEX_W-1:0] host_index;
		logic [BYTE_W-1:0]  host_byte;
		logic               status;
		logic [LEN_W-1:0]   host_len;
		logic [PORT_W-1:0]  port;
		logic               run_end;
	} res_t;

	typedef struct packed {
		logic [1:0]      cnt;
		res_t [1:0]      r;
	} step_out_t;

	function automatic res_t finish_res(input logic err, input logic [LEN_W-1:0] len,
		input logic [ACC_W-1:0] acc);
		res_t f;
		f = '0;
		f.kind = KIND_FINISH;
		if (err) begin
			f.status = STATUS_ERR;
		end else begin
			f.status   = STATUS_OK;
			f.host_len = len;
			f.port     = acc[PORT_W-1:0];
		end
		return f;
	endfunction

endpackage

// ----- hw/rtl/uhp_if.sv -----
`timescale 1ns / 1ps

interface uhp_req_if import uhp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_req;
	logic              last;

	modport source (output valid, output byte_req, output last, input ready);
	modport sink (input valid, input byte_req, input last, output ready);
endinterface

interface uhp_res_if import uhp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [INDEX_W-1:0] host_index;
	logic [BYTE_W-1:0]  host_byte;
	logic               status;
	logic [LEN_W-1:0]   host_len;
	logic [PORT_W-1:0]  port;
	logic               run_end;

	modport source (output valid, output kind, output host_index, output host_byte,
		output status, output host_len, output port, output run_end, input ready);
	modport sink (input valid, input kind, input host_index, input host_byte,
		input status, input host_len, input port, input run_end, output ready);
endinterface

// ----- hw/rtl/uhp_step.sv -----
`timescale 1ns / 1ps

module uhp_step import uhp_pkg::*; #(
	parameter int HOST_MAX        = HOST_MAX_DEF,
	parameter int PORT_DIGITS_MAX = PORT_DIGITS_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  logic [BYTE_W-1:0] byte_req,
	input  logic              last,
	output step_out_t         res
);

	localparam int HCW = $clog2(HOST_MAX + 1);

	typedef enum logic [2:0] {
		PH_SCHEME,
		PH_COLON,
		PH_SLASH,
		PH_HOST,
		PH_PORT,
		PH_DONE
	} phase_t;

	phase_t             phase_q, n_ph;
	logic [HCW-1:0]     hc_q, n_hc;
	logic               pd_q, n_pd;
	logic [DIG_W-1:0]   dig_q, n_dig;
	logic [ACC_W-1:0]   acc_q, n_acc;

	logic is_alpha, is_digit, is_dot, is_colon, is_slash, is_dash;
	logic do_scheme, do_host, do_port, do_store, fin, fin_err;
	logic main_v, end_v;
	res_t main_r, end_r;

	assign is_alpha = (byte_req >= CH_UP_A && byte_req <= CH_UP_Z) ||
		(byte_req >= CH_LO_A && byte_req <= CH_LO_Z);
	assign is_digit = byte_req >= CH_0 && byte_req <= CH_9;
	assign is_dot   = byte_req == CH_DOT;
	assign is_colon = byte_req == CH_COLON;
	assign is_slash = byte_req == CH_SLASH;
	assign is_dash  = byte_req == CH_DASH;

	always_comb begin
		n_ph      = phase_q;
		n_hc      = hc_q;
		n_pd      = pd_q;
		n_dig     = dig_q;
		n_acc     = acc_q;
		do_scheme = 1'b0;
		do_host   = 1'b0;
		do_port   = 1'b0;
		do_store  = 1'b0;
		fin       = 1'b0;
		fin_err   = 1'b0;
		main_v    = 1'b0;
		main_r    = '0;
		end_v     = 1'b0;
		end_r     = '0;

		if (phase_q != PH_DONE) begin
			if (byte_req == CH_NUL) begin
				fin     = 1'b1;
				fin_err = dig_q == '0;
			end else begin
				unique case (phase_q)
					PH_SCHEME: do_scheme = 1'b1;
					PH_COLON: begin
						if (is_slash) n_ph = PH_SLASH;
						else do_scheme = 1'b1;
					end
					PH_SLASH: begin
						if (is_slash) begin
							n_hc = '0;
							n_pd = 1'b0;
							n_ph = PH_HOST;
						end else begin
							do_scheme = 1'b1;
						end
					end
					PH_HOST: do_host = 1'b1;
					PH_PORT: do_port = 1'b1;
					default: n_ph = PH_DONE;
				endcase
			end
		end

		if (do_scheme) begin
			n_ph = PH_SCHEME;
			if (is_dot || is_digit) begin
				n_ph    = PH_HOST;
				do_host = 1'b1;
			end else if (is_alpha || is_dash) begin
				do_store = 1'b1;
			end else if (is_colon) begin
				n_ph = PH_COLON;
			end
		end

		if (do_host) begin
			if (is_dot) begin
				if (n_hc != '0 && n_pd) begin
					fin     = 1'b1;
					fin_err = 1'b1;
				end else begin
					do_store = 1'b1;
				end
			end else if (is_alpha || is_digit || is_dash) begin
				do_store = 1'b1;
			end else if (is_colon) begin
				n_ph = PH_PORT;
			end else if (is_slash) begin
				n_acc = '0;
				fin   = 1'b1;
			end
		end

		if (do_port) begin
			if (is_dot) begin
				fin     = 1'b1;
				fin_err = 1'b1;
			end else if (!is_digit) begin
				fin = 1'b1;
			end else if (dig_q >= DIG_W'(PORT_DIGITS_MAX)) begin
				fin     = 1'b1;
				fin_err = 1'b1;
			end else begin
				n_acc = (acc_q << 3) + (acc_q << 1) + ACC_W'(byte_req - CH_0);
				n_dig = dig_q + DIG_W'(1);
			end
		end

		if (do_store) begin
			if (n_hc >= HCW'(HOST_MAX)) begin
				fin     = 1'b1;
				fin_err = 1'b1;
			end else begin
				main_v            = 1'b1;
				main_r.kind       = KIND_HOST;
				main_r.host_index = INDEX_W'(n_hc);
				main_r.host_byte  = byte_req;
				n_hc              = n_hc + HCW'(1);
				n_pd              = is_dot;
			end
		end

		if (fin) begin
			main_v = 1'b1;
			main_r = finish_res(fin_err, LEN_W'(n_hc), n_acc);
			n_ph   = PH_DONE;
		end

		if (last) begin
			if (n_ph != PH_DONE) begin
				end_v = 1'b1;
				end_r = finish_res(n_dig == '0, LEN_W'(n_hc), n_acc);
			end
			n_ph  = PH_SCHEME;
			n_hc  = '0;
			n_pd  = 1'b0;
			n_dig = '0;
			n_acc = '0;
		end

		main_r.run_end = !end_v;
		end_r.run_end  = 1'b1;
		res.cnt        = {1'b0, main_v} + {1'b0, end_v};
		res.r[0]       = main_v ? main_r : end_r;
		res.r[1]       = end_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCHEME;
			hc_q    <= '0;
			pd_q    <= 1'b0;
			dig_q   <= '0;
			acc_q   <= '0;
		end else if (commit) begin
			phase_q <= n_ph;
			hc_q    <= n_hc;
			pd_q    <= n_pd;
			dig_q   <= n_dig;
			acc_q   <= n_acc;
		end
	end

endmodule

// ----- hw/rtl/uhp_out_fifo.sv -----
`timescale 1ns / 1ps

module uhp_out_fifo import uhp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_en,
	input  step_out_t push,
	output logic      space,
	output logic      head_valid,
	output res_t      head,
	input  logic      pop_ready
);

	res_t                 mem [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wp_q, rp_q;
	logic [OUT_CNT_W-1:0] cnt_q;
	logic [1:0]           wr_cnt;
	logic                 pop;

	assign wr_cnt     = push_en ? push.cnt : 2'd0;
	assign head_valid = cnt_q != '0;
	assign head       = mem[rp_q];
	assign pop        = head_valid && pop_ready;
	assign space      = cnt_q <= OUT_CNT_W'(OUT_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) mem[wp_q] <= push.r[0];
		if (wr_cnt == 2'd2) mem[wp_q + OUT_PTR_W'(1)] <= push.r[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OUT_PTR_W'(wr_cnt);
			rp_q  <= rp_q + OUT_PTR_W'(pop);
			cnt_q <= cnt_q + OUT_CNT_W'(wr_cnt) - OUT_CNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("output queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_cnt != 2'd0 |-> (cnt_q + OUT_CNT_W'(wr_cnt)) <= OUT_CNT_W'(OUT_DEPTH))
		else $error("output queue written while full");

	a_double_push: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_cnt == 2'd2 && !pop) |=> cnt_q == $past(cnt_q) + OUT_CNT_W'(2))
		else $error("two-word push lost a word");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		wr_cnt == 2'd2 |-> (push.r[1].run_end && !push.r[0].run_end))
		else $error("run end marked on the wrong word");

endmodule

// ----- hw/rtl/url_host_port_parser_core.sv -----
`timescale 1ns / 1ps
// A byte's first result is offered after the parse step has pushed it into the output queue.
// Throughput: one byte per cycle; a byte that yields two results pushes two queue words.
// The rate is set by the combinational parse step between the input register and the
// four-word output queue, which accepts a byte only while two free places remain.
// Reset is asynchronous and active low; it empties the queue and returns to the scheme phase.

module url_host_port_parser_core import uhp_pkg::*; #(
	parameter int HOST_MAX        = HOST_MAX_DEF,
	parameter int PORT_DIGITS_MAX = PORT_DIGITS_MAX_DEF
) (
	input logic       clk,
	input logic       arst_n,
	uhp_req_if.sink   req_ch,
	uhp_res_if.source res_ch
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              space;
	logic              commit;
	step_out_t         step_res;
	res_t              head;

	assign commit       = valid_s1 && space;
	assign req_ch.ready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ch.ready) begin
			valid_s1 <= req_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			byte_s1 <= req_ch.byte_req;
			last_s1 <= req_ch.last;
		end
	end

	uhp_step #(
		.HOST_MAX        (HOST_MAX),
		.PORT_DIGITS_MAX (PORT_DIGITS_MAX)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (commit),
		.byte_req (byte_s1),
		.last     (last_s1),
		.res      (step_res)
	);

	uhp_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_en    (commit),
		.push       (step_res),
		.space      (space),
		.head_valid (res_ch.valid),
		.head       (head),
		.pop_ready  (res_ch.ready)
	);

	assign res_ch.kind       = head.kind;
	assign res_ch.host_index = head.host_index;
	assign res_ch.host_byte  = head.host_byte;
	assign res_ch.status     = head.status;
	assign res_ch.host_len   = head.host_len;
	assign res_ch.port       = head.port;
	assign res_ch.run_end    = head.run_end;

endmodule
